// ===== sv/ple_pkg.sv =====
`timescale 1ns / 1ps

package ple_pkg;

   localparam int VALUE_W  = 32;
   localparam int POS_W    = 7;
   localparam int FOUND_W  = 6;
   localparam int LENGTH_W = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_FIND     = 2'd2,
      OP_RETRIEVE = 2'd3
   } ple_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } ple_status_type;

   typedef enum logic [3:0] {
      PS_IDLE,
      PS_MOVE,
      PS_DRAIN,
      PS_PUT,
      PS_FIND,
      PS_FIND_TAIL,
      PS_READ,
      PS_READ_WAIT,
      PS_RESP
   } ple_state_type;

endpackage

// ===== sv/ple_req_if.sv =====
`timescale 1ns / 1ps

interface ple_req_if;
   logic                               valid;
   logic                               ready;
   logic [ple_pkg::OP_W-1:0]           req_type;
   logic [ple_pkg::POS_W-1:0]          position;
   logic signed [ple_pkg::VALUE_W-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink (input valid, input req_type, input position, input value,
                 output ready);
endinterface

// ===== sv/ple_rsp_if.sv =====
`timescale 1ns / 1ps

interface ple_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ple_pkg::STATUS_W-1:0]       status;
   logic [ple_pkg::FOUND_W-1:0]        found_position;
   logic signed [ple_pkg::VALUE_W-1:0] read_value;
   logic [ple_pkg::LENGTH_W-1:0]       length;

   modport source (output valid, output status, output found_position,
                   output read_value, output length, input ready);
   modport sink (input valid, input status, input found_position,
                 input read_value, input length, output ready);
endinterface

// ===== sv/ple_ram.sv =====
`timescale 1ns / 1ps

module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/positional_list_engine.sv =====
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit values held in a single RAM with one write
// and one registered read port. One request is handled at a time and each gives one
// response; the request channel is not ready from acceptance until the response transfer.
// Entries move or are scanned one per cycle through that RAM port; a find stops at the
// first match, and a rejected request goes straight to the response. No clearing pass
// is needed after reset.
module positional_list_engine #(
   parameter int CAPACITY = 64
) (
   input logic      clock,
   input logic      reset,
   ple_req_if.sink  req_chan,
   ple_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

   ple_pkg::ple_state_type  state_ff, state_in;
   ple_pkg::ple_op_type     op_ff, op_in;
   ple_pkg::ple_status_type status_ff, status_in;

   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                pos_a_ff, pos_a_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic [AW-1:0]                last_ff, last_in;
   logic                         have_ff, have_in;
   logic                         chk_ff, chk_in;
   logic [ple_pkg::VALUE_W-1:0]  val_ff, val_in;
   logic [AW-1:0]                found_ff, found_in;
   logic [ple_pkg::VALUE_W-1:0]  rdval_ff, rdval_in;

   logic                         req_fire;
   logic [XW-1:0]                pos_x;
   logic [XW-1:0]                cnt_x;
   logic                         pos_gt_cnt;
   logic                         pos_ge_cnt;
   logic                         list_full;
   logic [AW-1:0]                cnt_m1;
   logic                         hit;

   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic [ple_pkg::VALUE_W-1:0]  ram_wdata;
   logic [ple_pkg::VALUE_W-1:0]  ram_rdata;

   ple_ram #(
      .WIDTH (ple_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign pos_x      = XW'(req_chan.position);
   assign cnt_x      = XW'(count_ff);
   assign pos_gt_cnt = pos_x > cnt_x;
   assign pos_ge_cnt = pos_x >= cnt_x;
   assign list_full  = count_ff == CW'(CAPACITY);
   assign cnt_m1     = AW'(count_ff - CW'(1));
   assign hit        = ram_rdata == val_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::PS_IDLE: begin
            if (req_fire) begin
               case (ple_pkg::ple_op_type'(req_chan.req_type))
                  ple_pkg::OP_INSERT: begin
                     if (pos_gt_cnt || list_full) begin
                        state_in = ple_pkg::PS_RESP;
                     end else if (pos_x == cnt_x) begin
                        state_in = ple_pkg::PS_PUT;
                     end else begin
                        state_in = ple_pkg::PS_MOVE;
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     if (pos_ge_cnt) begin
                        state_in = ple_pkg::PS_RESP;
                     end else if (pos_x[AW-1:0] == cnt_m1) begin
                        // Removing the tail entry moves nothing.
                        state_in = ple_pkg::PS_DRAIN;
                     end else begin
                        state_in = ple_pkg::PS_MOVE;
                     end
                  end
                  ple_pkg::OP_FIND: begin
                     if (count_ff == '0) begin
                        state_in = ple_pkg::PS_RESP;
                     end else begin
                        state_in = ple_pkg::PS_FIND;
                     end
                  end
                  default: begin
                     if (pos_ge_cnt) begin
                        state_in = ple_pkg::PS_RESP;
                     end else begin
                        state_in = ple_pkg::PS_READ;
                     end
                  end
               endcase
            end
         end
         ple_pkg::PS_MOVE: begin
            if ((op_ff == ple_pkg::OP_INSERT && ptr_ff == pos_a_ff) ||
                (op_ff != ple_pkg::OP_INSERT && ptr_ff == cnt_m1)) begin
               state_in = ple_pkg::PS_DRAIN;
            end
         end
         ple_pkg::PS_DRAIN: begin
            if (op_ff == ple_pkg::OP_INSERT) begin
               state_in = ple_pkg::PS_PUT;
            end else begin
               state_in = ple_pkg::PS_RESP;
            end
         end
         ple_pkg::PS_PUT:       state_in = ple_pkg::PS_RESP;
         ple_pkg::PS_FIND: begin
            if (chk_ff && hit) begin
               state_in = ple_pkg::PS_RESP;
            end else if (ptr_ff == cnt_m1) begin
               state_in = ple_pkg::PS_FIND_TAIL;
            end
         end
         ple_pkg::PS_FIND_TAIL: state_in = ple_pkg::PS_RESP;
         ple_pkg::PS_READ:      state_in = ple_pkg::PS_READ_WAIT;
         ple_pkg::PS_READ_WAIT: state_in = ple_pkg::PS_RESP;
         ple_pkg::PS_RESP: begin
            if (rsp_chan.ready) begin
               state_in = ple_pkg::PS_IDLE;
            end
         end
         default:               state_in = ple_pkg::PS_IDLE;
      endcase
   end

   // Datapath controls and register updates.
   always_comb begin
      op_in     = op_ff;
      pos_a_in  = pos_a_ff;
      val_in    = val_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rdval_in  = rdval_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      last_in   = last_ff;
      have_in   = 1'b0;
      chk_in    = 1'b0;
      ram_we    = have_ff;
      ram_wdata = ram_rdata;
      if (op_ff == ple_pkg::OP_INSERT) begin
         ram_waddr = last_ff + AW'(1);
      end else begin
         ram_waddr = last_ff - AW'(1);
      end

      case (state_ff)
         ple_pkg::PS_IDLE: begin
            if (req_fire) begin
               op_in     = ple_pkg::ple_op_type'(req_chan.req_type);
               pos_a_in  = pos_x[AW-1:0];
               val_in    = req_chan.value;
               found_in  = '0;
               rdval_in  = '0;
               status_in = ple_pkg::ST_DONE;
               case (ple_pkg::ple_op_type'(req_chan.req_type))
                  ple_pkg::OP_INSERT: begin
                     ptr_in = cnt_m1;
                     if (pos_gt_cnt) begin
                        status_in = ple_pkg::ST_MISSING;
                     end else if (list_full) begin
                        status_in = ple_pkg::ST_FULL;
                     end
                  end
                  ple_pkg::OP_REMOVE: begin
                     ptr_in = pos_x[AW-1:0] + AW'(1);
                     if (pos_ge_cnt) begin
                        status_in = ple_pkg::ST_MISSING;
                     end
                  end
                  ple_pkg::OP_FIND: begin
                     ptr_in    = '0;
                     status_in = ple_pkg::ST_MISSING;
                  end
                  default: begin
                     ptr_in = pos_x[AW-1:0];
                     if (pos_ge_cnt) begin
                        status_in = ple_pkg::ST_MISSING;
                     end
                  end
               endcase
            end
         end
         ple_pkg::PS_MOVE: begin
            // Read one entry while the previous read is written one place over.
            have_in = 1'b1;
            last_in = ptr_ff;
            if (op_ff == ple_pkg::OP_INSERT) begin
               ptr_in = ptr_ff - AW'(1);
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ple_pkg::PS_DRAIN: begin
            if (op_ff != ple_pkg::OP_INSERT) begin
               count_in = count_ff - CW'(1);
            end
         end
         ple_pkg::PS_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = pos_a_ff;
            ram_wdata = val_ff;
            count_in  = count_ff + CW'(1);
         end
         ple_pkg::PS_FIND: begin
            chk_in  = 1'b1;
            last_in = ptr_ff;
            ptr_in  = ptr_ff + AW'(1);
            if (chk_ff && hit) begin
               status_in = ple_pkg::ST_DONE;
               found_in  = last_ff;
            end
         end
         ple_pkg::PS_FIND_TAIL: begin
            if (hit) begin
               status_in = ple_pkg::ST_DONE;
               found_in  = last_ff;
            end
         end
         ple_pkg::PS_READ_WAIT: begin
            rdval_in = ram_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::PS_IDLE;
         count_ff <= '0;
         have_ff  <= 1'b0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         have_ff  <= have_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_a_ff  <= pos_a_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rdval_ff  <= rdval_in;
      ptr_ff    <= ptr_in;
      last_ff   <= last_in;
   end

   assign req_chan.ready          = state_ff == ple_pkg::PS_IDLE;
   assign rsp_chan.valid          = state_ff == ple_pkg::PS_RESP;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.found_position = ple_pkg::FOUND_W'(found_ff);
   assign rsp_chan.read_value     = rdval_ff;
   assign rsp_chan.length         = ple_pkg::LENGTH_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_write_window: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ple_pkg::PS_MOVE || state_ff == ple_pkg::PS_DRAIN ||
                  state_ff == ple_pkg::PS_PUT))
      else $error("list store written outside a shift or insert step");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         ($past(state_ff) == ple_pkg::PS_PUT || $past(state_ff) == ple_pkg::PS_DRAIN))
      else $error("entry count changed outside the final step of insert or remove");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && status_ff == ple_pkg::ST_FULL) |-> list_full)
      else $error("full status reported while the list has room");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CAPACITY    = 64;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 100;
   localparam int PRINT_CAP   = 30;

   localparam logic signed [ple_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [ple_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct {
      ple_pkg::ple_status_type              status;
      logic [ple_pkg::FOUND_W-1:0]          found_position;
      logic signed [ple_pkg::VALUE_W-1:0]   read_value;
      logic [ple_pkg::LENGTH_W-1:0]         length;
   } list_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req_chan ();
   ple_rsp_if rsp_chan ();

   positional_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copy of the list, updated as each request is accepted.
   logic signed [ple_pkg::VALUE_W-1:0] list_store [CAPACITY];
   int list_len = 0;

   list_result_type expected_results [$];

   int  error_count     = 0;
   int  requests_sent   = 0;
   int  results_checked = 0;
   int  full_rejects    = 0;
   int  range_rejects   = 0;
   int  finds_hit       = 0;
   int  cycle_count     = 0;
   int  holds_asked     = 0;
   int  holds_served    = 0;
   int  hold_left       = 0;
   bit  no_idle         = 1'b0;
   bit  growing         = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("tb: failure");
         $finish;
      end
   end

   function automatic list_result_type predict_list_op(ple_pkg::ple_op_type op,
                                                       logic [ple_pkg::POS_W-1:0] pos,
                                                       logic signed [ple_pkg::VALUE_W-1:0] val);
      list_result_type r;
      r.status         = ple_pkg::ST_DONE;
      r.found_position = '0;
      r.read_value     = '0;
      case (op)
         ple_pkg::OP_INSERT: begin
            // A position past the end is rejected before the list is checked for room.
            if (pos > list_len) begin
               r.status = ple_pkg::ST_MISSING;
            end else if (list_len >= CAPACITY) begin
               r.status = ple_pkg::ST_FULL;
            end else begin
               for (int k = list_len; k > pos; k--) list_store[k] = list_store[k-1];
               list_store[pos[IDX_W-1:0]] = val;
               list_len++;
            end
         end
         ple_pkg::OP_REMOVE: begin
            if (pos >= list_len) begin
               r.status = ple_pkg::ST_MISSING;
            end else begin
               for (int k = pos; k + 1 < list_len; k++) list_store[k] = list_store[k+1];
               list_len--;
            end
         end
         ple_pkg::OP_FIND: begin
            r.status = ple_pkg::ST_MISSING;
            for (int k = 0; k < list_len; k++) begin
               if (list_store[k] == val) begin
                  r.status         = ple_pkg::ST_DONE;
                  r.found_position = k[ple_pkg::FOUND_W-1:0];
                  break;
               end
            end
            if (r.status == ple_pkg::ST_DONE) finds_hit++;
         end
         default: begin
            if (pos >= list_len) r.status = ple_pkg::ST_MISSING;
            else r.read_value = list_store[pos[IDX_W-1:0]];
         end
      endcase
      if (r.status == ple_pkg::ST_FULL) full_rejects++;
      if (r.status == ple_pkg::ST_MISSING && op != ple_pkg::OP_FIND) range_rejects++;
      r.length = list_len[ple_pkg::LENGTH_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < PRINT_CAP)
         $display("tb: mismatch, %s at result %0d: got %h, expected %h",
                  what, results_checked, got, want);
      error_count++;
   endtask

   // Response side: random stalls, plus a long hold-off whenever a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served   <= holds_asked;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 32);
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request waiting", 32'(rsp_chan.status), '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", 32'(rsp_chan.status), 32'(want.status));
            if (rsp_chan.found_position !== want.found_position)
               report_mismatch("found_position", 32'(rsp_chan.found_position),
                               32'(want.found_position));
            if (rsp_chan.read_value !== want.read_value)
               report_mismatch("read_value", rsp_chan.read_value, want.read_value);
            if (rsp_chan.length !== want.length)
               report_mismatch("length", 32'(rsp_chan.length), 32'(want.length));
         end
         results_checked++;
      end
   end

   // Valid stays high from one request to the next unless the sender idles, so it is
   // never lowered and raised in the same step.
   task automatic send_request(ple_pkg::ple_op_type op, logic [ple_pkg::POS_W-1:0] pos,
                               logic signed [ple_pkg::VALUE_W-1:0] val);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(99) < 32) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.position <= pos;
      req_chan.value    <= val;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_list_op(op, pos, val));
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom();
         1: begin
            case ($urandom_range(3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return $signed($urandom_range(15)) - 8;
      endcase
   endfunction

   function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_find_value();
      if (list_len > 0 && $urandom_range(99) < 60)
         return list_store[$urandom_range(list_len - 1)];
      return pick_value();
   endfunction

   // Mostly legal positions; the list drifts between empty and full so that both
   // boundaries are reached again and again.
   task automatic random_request();
      int roll;
      ple_pkg::ple_op_type op;
      logic [ple_pkg::POS_W-1:0] pos;
      logic signed [ple_pkg::VALUE_W-1:0] val;
      if (list_len == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      else if (list_len == 0 && $urandom_range(3) == 0) growing = 1'b1;
      else if ($urandom_range(99) == 0) growing = !growing;
      roll = $urandom_range(99);
      if (roll < (growing ? 45 : 15)) op = ple_pkg::OP_INSERT;
      else if (roll < 60) op = ple_pkg::OP_REMOVE;
      else if (roll < 80) op = ple_pkg::OP_FIND;
      else op = ple_pkg::OP_RETRIEVE;
      if ($urandom_range(99) < 15) pos = ple_pkg::POS_W'($urandom_range(127));
      else if (op == ple_pkg::OP_INSERT) pos = ple_pkg::POS_W'($urandom_range(list_len));
      else if (list_len == 0) pos = '0;
      else pos = ple_pkg::POS_W'($urandom_range(list_len - 1));
      val = (op == ple_pkg::OP_FIND) ? pick_find_value() : pick_value();
      send_request(op, pos, val);
   endtask

   task automatic test_directed();
      // Every operation on an empty list is rejected.
      send_request(ple_pkg::OP_REMOVE, 0, 0);
      send_request(ple_pkg::OP_RETRIEVE, 0, 0);
      send_request(ple_pkg::OP_FIND, 0, 0);
      send_request(ple_pkg::OP_INSERT, 1, 5);
      send_request(ple_pkg::OP_INSERT, 127, VALUE_MAX);
      // Removing the only entry must leave a clean empty list.
      send_request(ple_pkg::OP_INSERT, 0, VALUE_MIN);
      send_request(ple_pkg::OP_REMOVE, 0, 0);
      send_request(ple_pkg::OP_INSERT, 0, VALUE_MIN);
      send_request(ple_pkg::OP_INSERT, 1, VALUE_MAX);
      send_request(ple_pkg::OP_INSERT, 0, -1);
      send_request(ple_pkg::OP_INSERT, 1, 0);
      send_request(ple_pkg::OP_INSERT, 2, -1);
      // Duplicate value: the first position must be reported.
      send_request(ple_pkg::OP_FIND, 0, -1);
      send_request(ple_pkg::OP_FIND, 0, VALUE_MAX);
      send_request(ple_pkg::OP_FIND, 0, 12345);
      send_request(ple_pkg::OP_RETRIEVE, 0, 0);
      send_request(ple_pkg::OP_RETRIEVE, 4, 0);
      send_request(ple_pkg::OP_RETRIEVE, 5, 0);
      send_request(ple_pkg::OP_RETRIEVE, 127, 0);
      send_request(ple_pkg::OP_REMOVE, 5, 0);
      send_request(ple_pkg::OP_REMOVE, 4, 0);
      send_request(ple_pkg::OP_REMOVE, 0, 0);
      send_request(ple_pkg::OP_RETRIEVE, 0, 0);
   endtask

   task automatic test_fill_and_full();
      while (list_len < CAPACITY)
         send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'($urandom_range(list_len)),
                      pick_value());
      send_request(ple_pkg::OP_REMOVE, ple_pkg::POS_W'(CAPACITY - 1), 0);
      send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(CAPACITY - 1), 32'sh5a5a_a5a5);
      send_request(ple_pkg::OP_FIND, 0, 32'sh5a5a_a5a5);
      send_request(ple_pkg::OP_RETRIEVE, ple_pkg::POS_W'(CAPACITY - 1), 0);
      send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(CAPACITY), 1);
      send_request(ple_pkg::OP_INSERT, 0, 2);
      // Past the end on a full list reports the position, not the lack of room.
      send_request(ple_pkg::OP_INSERT, ple_pkg::POS_W'(CAPACITY + 1), 3);
      send_request(ple_pkg::OP_RETRIEVE, ple_pkg::POS_W'(CAPACITY), 0);
      send_request(ple_pkg::OP_REMOVE, ple_pkg::POS_W'(CAPACITY), 0);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      holds_asked <= holds_asked + 1;
      repeat (16) random_request();
   endtask

   task automatic test_random_mix(int count);
      repeat (count) random_request();
   endtask

   task automatic test_without_idling(int count);
      no_idle <= 1'b1;
      repeat (count) random_request();
      wait_for_results();
      no_idle <= 1'b0;
   endtask

   initial begin
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= ple_pkg::OP_INSERT;
      req_chan.position <= '0;
      req_chan.value    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_full();
      test_backpressure();
      test_random_mix(470);
      test_without_idling(60);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d requests, %0d results compared, %0d mismatches",
               requests_sent, results_checked, error_count);
      $display("tb: %0d full-list rejections, %0d bad positions, %0d finds that hit",
               full_rejects, range_rejects, finds_hit);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
